// ----- src/bffa_pkg.sv -----
`default_nettype none

package bffa_pkg;

   // default pool geometry
   localparam int BLOCK_COUNT_DEF = 1024;
   localparam int BLOCK_BYTES     = 512;
   localparam int BLOCK_SHIFT     = 9;
   localparam int WORD_BITS       = 32;
   localparam int WORD_SHIFT      = 5;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NULL    = 2'd1,
      ST_UNKNOWN = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN_EV,
      S_SET_RD,
      S_SET_WR,
      S_LEN_RD,
      S_LEN_EV,
      S_FINISH,
      S_FAIL_NULL,
      S_FAIL_UNKNOWN
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic scan_ev;
      logic set_wr;
      logic len_ev;
      logic finish;
      logic fail_null;
      logic fail_unknown;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic op_free;
      logic zero_req;
      logic too_big;
      logic out_range;
      logic hit;
      logic last_word;
      logic set_last;
      logic len_zero;
   } stat_type;

endpackage

`default_nettype wire

// ----- src/bffa_ctrl.sv -----
`default_nettype none

module bffa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire bffa_pkg::stat_type stat,
   output bffa_pkg::cmd_type       cmd
);
   import bffa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (!stat.op_free) begin
               if (stat.zero_req || stat.too_big) state_in = S_FAIL_NULL;
               else                                state_in = S_SCAN_RD;
            end else begin
               if (stat.out_range) state_in = S_FAIL_NULL;
               else                state_in = S_LEN_RD;
            end
         end
         S_SCAN_RD: state_in = S_SCAN_EV;
         S_SCAN_EV: begin
            if (stat.hit)            state_in = S_SET_RD;
            else if (stat.last_word) state_in = S_FAIL_NULL;
            else                     state_in = S_SCAN_RD;
         end
         S_SET_RD: state_in = S_SET_WR;
         S_SET_WR: begin
            if (stat.set_last) state_in = S_FINISH;
            else               state_in = S_SET_RD;
         end
         S_LEN_RD: state_in = S_LEN_EV;
         S_LEN_EV: begin
            if (stat.len_zero) state_in = S_FAIL_UNKNOWN;
            else               state_in = S_SET_RD;
         end
         S_FINISH:       state_in = S_IDLE;
         S_FAIL_NULL:    state_in = S_IDLE;
         S_FAIL_UNKNOWN: state_in = S_IDLE;
         default:        state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         S_CLEAR:        cmd.clear_step = 1'b1;
         S_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         S_SCAN_EV:      cmd.scan_ev = 1'b1;
         S_SET_WR:       cmd.set_wr = 1'b1;
         S_LEN_EV:       cmd.len_ev = !stat.len_zero;
         S_FINISH:       cmd.finish = 1'b1;
         S_FAIL_NULL:    cmd.fail_null = 1'b1;
         S_FAIL_UNKNOWN: cmd.fail_unknown = 1'b1;
         default:        cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/bffa_dpath.sv -----
`default_nettype none

module bffa_dpath #(
   parameter int BLOCK_COUNT = bffa_pkg::BLOCK_COUNT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bffa_pkg::cmd_type  cmd,
   output bffa_pkg::stat_type      stat,
   input  wire logic               req_operation,
   input  wire logic [19:0]        req_byte_count,
   input  wire logic [19:0]        req_byte_offset,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic [18:0]             rsp_result_offset,
   output logic [10:0]             rsp_blocks_moved,
   output logic [31:0]             rsp_alloc_count,
   output logic [31:0]             rsp_free_count,
   output logic [31:0]             rsp_bytes_allocated_total,
   output logic [31:0]             rsp_bytes_freed_total
);
   import bffa_pkg::*;

   localparam int WORDS  = BLOCK_COUNT / WORD_BITS;
   localparam int IW     = $clog2(BLOCK_COUNT);
   localparam int LW     = $clog2(BLOCK_COUNT + 1);
   localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int RW     = LW + 1;
   localparam int NEED_W = 21 - BLOCK_SHIFT;
   localparam logic [31:0] POOL_BYTES = 32'(BLOCK_COUNT * BLOCK_BYTES);
   localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

   logic [WORD_BITS-1:0] bm_mem [WORDS];
   logic [LW-1:0]        len_mem [BLOCK_COUNT];

   logic                 op_ff, zero_ff, too_big_ff, out_range_ff;
   logic [IW-1:0]        block_ff, start_ff, end_ff, clr_ff;
   logic [LW-1:0]        len_ff, len_rd_ff;
   logic [WAW-1:0]       w_ff;
   logic [RW-1:0]        run_ff;
   logic [WORD_BITS-1:0] bm_rd_ff;
   logic [31:0]          alloc_cnt_ff, free_cnt_ff, alloc_bytes_ff, free_bytes_ff;
   logic                 rsp_strobe_ff;
   status_type           rsp_status_ff;
   logic [18:0]          rsp_offset_ff;
   logic [10:0]          rsp_blocks_ff;

   // request decode
   logic [20:0]       need_sum;
   logic [NEED_W-1:0] need;
   assign need_sum = {1'b0, req_byte_count} + 21'(BLOCK_BYTES - 1);
   assign need     = need_sum[20:BLOCK_SHIFT];

   // run length ending at each bit of the word under test
   logic [RW-1:0] run_bit [WORD_BITS];
   always_comb begin
      logic       found;
      logic [4:0] pos;
      for (int j = 0; j < WORD_BITS; j++) begin
         found = 1'b0;
         pos   = '0;
         for (int k = 0; k < WORD_BITS; k++) begin
            if (k <= j && bm_rd_ff[k]) begin
               found = 1'b1;
               pos   = 5'(k);
            end
         end
         if (found) run_bit[j] = RW'(5'(j) - pos);
         else       run_bit[j] = run_ff + RW'(j + 1);
      end
   end

   logic       hit;
   logic [4:0] hit_pos;
   always_comb begin
      hit     = 1'b0;
      hit_pos = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (run_bit[j] >= RW'(len_ff)) begin
            hit     = 1'b1;
            hit_pos = 5'(j);
         end
      end
   end

   logic [IW-1:0] hit_end, hit_start;
   assign hit_end   = IW'({w_ff, hit_pos});
   assign hit_start = hit_end - IW'(len_ff) + IW'(1);

   // bit mask of the run inside the current word
   logic [WAW-1:0]       sw, ew;
   logic [4:0]           lo, hi;
   logic [WORD_BITS-1:0] mask;
   assign sw   = WAW'(start_ff >> WORD_SHIFT);
   assign ew   = WAW'(end_ff >> WORD_SHIFT);
   assign lo   = (w_ff == sw) ? start_ff[4:0] : 5'd0;
   assign hi   = (w_ff == ew) ? end_ff[4:0] : 5'd31;
   assign mask = (ONES << lo) & (ONES >> (5'd31 - hi));

   always_comb begin
      stat.clear_done = (clr_ff == IW'(BLOCK_COUNT - 1));
      stat.op_free    = op_ff;
      stat.zero_req   = zero_ff;
      stat.too_big    = too_big_ff;
      stat.out_range  = out_range_ff;
      stat.hit        = hit;
      stat.last_word  = (w_ff == WAW'(WORDS - 1));
      stat.set_last   = (w_ff == ew);
      stat.len_zero   = (len_rd_ff == '0);
   end

   // memories
   always_ff @(posedge clock) begin
      bm_rd_ff  <= bm_mem[w_ff];
      len_rd_ff <= len_mem[block_ff];
      if (cmd.clear_step) begin
         bm_mem[WAW'(clr_ff >> WORD_SHIFT)] <= '0;
      end else if (cmd.set_wr) begin
         bm_mem[w_ff] <= op_ff ? (bm_rd_ff & ~mask) : (bm_rd_ff | mask);
      end
      if (cmd.clear_step) begin
         len_mem[clr_ff] <= '0;
      end else if (cmd.finish) begin
         len_mem[start_ff] <= op_ff ? '0 : len_ff;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= req_operation;
         zero_ff      <= (req_byte_count == '0);
         too_big_ff   <= (32'(need) > 32'(BLOCK_COUNT));
         out_range_ff <= ({12'd0, req_byte_offset} >= POOL_BYTES);
         block_ff     <= IW'(req_byte_offset >> BLOCK_SHIFT);
         len_ff       <= LW'(need);
         w_ff         <= '0;
         run_ff       <= '0;
      end else if (cmd.scan_ev) begin
         if (hit) begin
            start_ff <= hit_start;
            end_ff   <= hit_end;
            w_ff     <= WAW'(hit_start >> WORD_SHIFT);
         end else begin
            run_ff <= run_bit[WORD_BITS-1];
            w_ff   <= w_ff + WAW'(1);
         end
      end else if (cmd.len_ev) begin
         start_ff <= block_ff;
         end_ff   <= block_ff + IW'(len_rd_ff) - IW'(1);
         w_ff     <= WAW'(block_ff >> WORD_SHIFT);
         len_ff   <= len_rd_ff;
      end else if (cmd.set_wr) begin
         w_ff <= w_ff + WAW'(1);
      end
   end

   // clear sweep, counters, response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff         <= '0;
         alloc_cnt_ff   <= '0;
         free_cnt_ff    <= '0;
         alloc_bytes_ff <= '0;
         free_bytes_ff  <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + IW'(1);
         rsp_strobe_ff <= cmd.finish || cmd.fail_null || cmd.fail_unknown;
         if (cmd.finish) begin
            if (op_ff == OP_FREE) begin
               free_cnt_ff   <= free_cnt_ff + 32'd1;
               free_bytes_ff <= free_bytes_ff + (32'(len_ff) << BLOCK_SHIFT);
            end else begin
               alloc_cnt_ff   <= alloc_cnt_ff + 32'd1;
               alloc_bytes_ff <= alloc_bytes_ff + (32'(len_ff) << BLOCK_SHIFT);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= ST_OK;
         rsp_offset_ff <= 19'(32'(start_ff) << BLOCK_SHIFT);
         rsp_blocks_ff <= 11'(len_ff);
      end else if (cmd.fail_null || cmd.fail_unknown) begin
         rsp_status_ff <= cmd.fail_null ? ST_NULL : ST_UNKNOWN;
         rsp_offset_ff <= '0;
         rsp_blocks_ff <= '0;
      end
   end

   assign rsp_strobe                = rsp_strobe_ff;
   assign rsp_status                = rsp_status_ff;
   assign rsp_result_offset         = rsp_offset_ff;
   assign rsp_blocks_moved          = rsp_blocks_ff;
   assign rsp_alloc_count           = alloc_cnt_ff;
   assign rsp_free_count            = free_cnt_ff;
   assign rsp_bytes_allocated_total = alloc_bytes_ff;
   assign rsp_bytes_freed_total     = free_bytes_ff;

endmodule

`default_nettype wire

// ----- src/bitmap_first_fit_block_allocator.sv -----
`default_nettype none

// Block pool allocator, first fit over a used-block bitmap. Pulse start while
// busy is low to issue one transaction: allocate (byte count rounded up to
// whole 512-byte blocks) or free (byte offset, the block holding it is the
// run start). Exactly one response comes back per transaction, on rsp_strobe
// for a single cycle; it cannot be held off, so capture it when it appears.
// After reset the block runs a clearing sweep over every block with busy
// high before the first transaction is taken. The bitmap memory is 32 bits
// wide with a registered read, and every word visited is first read, then
// evaluated or updated. An allocate decodes the request, scans words until
// a free run is found, then reads and sets each word touched by the run and
// finishes. A free decodes, reads the run-length table, then reads and
// clears each word touched and finishes. Failed requests finish early.
module bitmap_first_fit_block_allocator #(
   parameter int BLOCK_COUNT = bffa_pkg::BLOCK_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [19:0] req_byte_count,
   input  wire logic [19:0] req_byte_offset,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [18:0]      rsp_result_offset,
   output logic [10:0]      rsp_blocks_moved,
   output logic [31:0]      rsp_alloc_count,
   output logic [31:0]      rsp_free_count,
   output logic [31:0]      rsp_bytes_allocated_total,
   output logic [31:0]      rsp_bytes_freed_total
);
   import bffa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: walks scan, set/clear and table update steps
   bffa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // bitmap, run-length table, counters and response registers
   bffa_dpath #(
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_dpath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .stat                      (stat),
      .req_operation             (req_operation),
      .req_byte_count            (req_byte_count),
      .req_byte_offset           (req_byte_offset),
      .rsp_strobe                (rsp_strobe),
      .rsp_status                (rsp_status),
      .rsp_result_offset         (rsp_result_offset),
      .rsp_blocks_moved          (rsp_blocks_moved),
      .rsp_alloc_count           (rsp_alloc_count),
      .rsp_free_count            (rsp_free_count),
      .rsp_bytes_allocated_total (rsp_bytes_allocated_total),
      .rsp_bytes_freed_total     (rsp_bytes_freed_total)
   );

`ifndef ASSERT_OFF
   // a response strobe is never asserted back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held two cycles");

   // an accepted transaction keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // failures carry no offset and no block count
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |->
         (rsp_result_offset == '0 && rsp_blocks_moved == '0))
      else $error("failed response with payload");

   // no response while the block sits idle without a pending transaction
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy)) |-> !rsp_strobe)
      else $error("response without transaction");
`endif

endmodule

`default_nettype wire
